>>> sv/crou_pkg.sv
// Shared types and constants for the circular range overlap/union block.
// No dependencies; imported by every module of the block.
`default_nettype none

package crou_pkg;

  localparam int ANGLE_BITS = 16;

  typedef logic [ANGLE_BITS-1:0] angle_t;

  // sort key codes
  localparam logic [1:0] KEY_LOWER = 2'd0;
  localparam logic [1:0] KEY_UPPER = 2'd1;
  localparam logic [1:0] KEY_SIZE  = 2'd2;

  localparam logic [1:0] SORT_KEY_RESET = KEY_SIZE;

  typedef struct packed {
    angle_t lo;
    angle_t up;
    logic   empty;
    logic   full;
  } range_t;

  // compare results carried from the compare stage to the resolve stage
  typedef struct packed {
    logic a_empty;
    logic b_empty;
    logic a_full;
    logic b_full;
    logic a_wrap;     // a.lo > a.up
    logic b_wrap;
    logic lo_lt;      // a.lo < b.lo
    logic lo_gt;      // a.lo > b.lo
    logic up_lt;      // a.up < b.up
    logic up_gt;      // a.up > b.up
    logic alo_le_bup; // a.lo <= b.up
    logic blo_le_aup; // b.lo <= a.up
    logic p_inside;
  } crou_flags_t;

  typedef struct packed {
    range_t ov;
    range_t un;
    logic   a_less;
    logic   a_greater;
    logic   a_equal;
    logic   point_inside;
  } crou_result_t;

endpackage

`default_nettype wire

>>> sv/crou_cmp.sv
// Compare stage: bound-to-bound compares, wrapped sizes and point test.
// Depends on crou_pkg.
`default_nettype none

module crou_cmp
  import crou_pkg::*;
(
  input  var range_t      a,
  input  var range_t      b,
  input  var angle_t      point,
  output crou_flags_t     flags,
  output angle_t          a_size,
  output angle_t          b_size
);

  logic a_wrap;

  assign a_wrap = a.lo > a.up;

  always_comb begin
    flags.a_empty    = a.empty;
    flags.b_empty    = b.empty;
    flags.a_full     = a.full;
    flags.b_full     = b.full;
    flags.a_wrap     = a_wrap;
    flags.b_wrap     = b.lo > b.up;
    flags.lo_lt      = a.lo < b.lo;
    flags.lo_gt      = b.lo < a.lo;
    flags.up_lt      = a.up < b.up;
    flags.up_gt      = b.up < a.up;
    flags.alo_le_bup = a.lo <= b.up;
    flags.blo_le_aup = b.lo <= a.up;
    if (a.empty) begin
      flags.p_inside = 1'b0;
    end else if (a.full) begin
      flags.p_inside = 1'b1;
    end else if (a_wrap) begin
      flags.p_inside = (point >= a.lo) || (point <= a.up);
    end else begin
      flags.p_inside = (point >= a.lo) && (point <= a.up);
    end
  end

  // modular difference, wraps naturally at ANGLE_BITS
  assign a_size = a.up - a.lo;
  assign b_size = b.up - b.lo;

endmodule

`default_nettype wire

>>> sv/crou_resolve.sv
// Resolve stage: picks overlap, union and ordering from the compare flags.
// Depends on crou_pkg.
`default_nettype none

module crou_resolve
  import crou_pkg::*;
(
  input  var crou_flags_t  flags,
  input  var angle_t       a_lo,
  input  var angle_t       a_up,
  input  var angle_t       b_lo,
  input  var angle_t       b_up,
  input  var angle_t       a_size,
  input  var angle_t       b_size,
  input  var logic [1:0]   sort_key,
  output crou_result_t     res
);

  angle_t min_lo, max_lo, min_up, max_up;
  logic   c1, c2, c5, c6, c3, c4;
  range_t r_empty, r_circle, r_a, r_b;
  range_t ov_sel, un_sel;
  logic   ord_less, ord_greater, same_bounds;

  assign min_lo = flags.lo_lt ? a_lo : b_lo;
  assign max_lo = flags.lo_lt ? b_lo : a_lo;
  assign min_up = flags.up_lt ? a_up : b_up;
  assign max_up = flags.up_lt ? b_up : a_up;

  assign c1 = !flags.up_lt;      // b.up <= a.up
  assign c2 = !flags.lo_gt;      // b.lo >= a.lo
  assign c5 = !flags.up_gt;      // a.up <= b.up
  assign c6 = !flags.lo_lt;      // a.lo >= b.lo
  assign c3 = flags.alo_le_bup;
  assign c4 = flags.blo_le_aup;

  assign r_empty  = '{lo: '0, up: '0, empty: 1'b1, full: 1'b0};
  assign r_circle = '{lo: '0, up: '0, empty: 1'b0, full: 1'b1};
  assign r_a      = '{lo: a_lo, up: a_up, empty: 1'b0, full: flags.a_full};
  assign r_b      = '{lo: b_lo, up: b_up, empty: 1'b0, full: flags.b_full};

  // overlap
  always_comb begin
    ov_sel = r_empty;
    if (flags.a_empty || flags.b_empty) begin
      ov_sel = r_empty;
    end else if (flags.a_full) begin
      ov_sel = r_b;
    end else if (flags.b_full) begin
      ov_sel = r_a;
    end else if (flags.a_wrap) begin
      if (flags.b_wrap) begin
        ov_sel = '{lo: max_lo, up: min_up, empty: 1'b0, full: 1'b0};
      end else if (c1 || c2) begin
        ov_sel = r_b;
      end else if (c3) begin
        ov_sel = '{lo: a_lo, up: b_up, empty: 1'b0, full: 1'b0};
      end else if (c4) begin
        ov_sel = '{lo: b_lo, up: a_up, empty: 1'b0, full: 1'b0};
      end
    end else if (flags.b_wrap) begin
      if (c5 || c6) begin
        ov_sel = r_a;
      end else if (c3) begin
        ov_sel = '{lo: a_lo, up: b_up, empty: 1'b0, full: 1'b0};
      end else if (c4) begin
        ov_sel = '{lo: b_lo, up: a_up, empty: 1'b0, full: 1'b0};
      end
    end else if (c3 && c4) begin
      ov_sel = '{lo: max_lo, up: min_up, empty: 1'b0, full: 1'b0};
    end
  end

  // union
  always_comb begin
    un_sel = r_empty;
    if (flags.a_empty || flags.b_empty) begin
      un_sel = r_empty;
    end else if (flags.a_full) begin
      un_sel = r_a;
    end else if (flags.b_full) begin
      un_sel = r_b;
    end else if (flags.a_wrap) begin
      if (flags.b_wrap) begin
        if (c3 || c4) begin
          un_sel = r_circle;
        end else begin
          un_sel = '{lo: min_lo, up: max_up, empty: 1'b0, full: 1'b0};
        end
      end else if (c1 || c2) begin
        un_sel = r_a;
      end else if (c3 && c4) begin
        un_sel = r_circle;
      end else if (c3) begin
        un_sel = '{lo: b_lo, up: a_up, empty: 1'b0, full: 1'b0};
      end else if (c4) begin
        un_sel = '{lo: a_lo, up: b_up, empty: 1'b0, full: 1'b0};
      end
    end else if (flags.b_wrap) begin
      if (c5 || c6) begin
        un_sel = r_b;
      end else if (c3 && c4) begin
        un_sel = r_circle;
      end else if (c3) begin
        un_sel = '{lo: b_lo, up: a_up, empty: 1'b0, full: 1'b0};
      end else if (c4) begin
        un_sel = '{lo: a_lo, up: b_up, empty: 1'b0, full: 1'b0};
      end
    end else if (c3 && c4) begin
      un_sel = '{lo: min_lo, up: max_up, empty: 1'b0, full: 1'b0};
    end
  end

  // ordering
  always_comb begin
    ord_less    = 1'b0;
    ord_greater = 1'b0;
    if (!flags.a_empty && !flags.b_empty) begin
      unique case (sort_key)
        KEY_LOWER: begin
          ord_less    = flags.lo_lt;
          ord_greater = flags.lo_gt;
        end
        KEY_UPPER: begin
          ord_less    = flags.up_lt;
          ord_greater = flags.up_gt;
        end
        KEY_SIZE: begin
          if (flags.a_full || flags.b_full) begin
            // full circle orders after any partial range
            ord_less    = flags.b_full && !flags.a_full;
            ord_greater = flags.a_full && !flags.b_full;
          end else begin
            ord_less    = a_size < b_size;
            ord_greater = b_size < a_size;
          end
        end
        default: begin
          ord_less    = 1'b0;
          ord_greater = 1'b0;
        end
      endcase
    end
  end

  always_comb begin
    if (!flags.a_empty && !flags.b_empty) begin
      same_bounds = !flags.lo_lt && !flags.lo_gt && !flags.up_lt && !flags.up_gt;
    end else begin
      same_bounds = flags.a_empty && flags.b_empty;
    end
  end

  assign res = '{ov: ov_sel, un: un_sel, a_less: ord_less, a_greater: ord_greater,
                 a_equal: same_bounds, point_inside: flags.p_inside};

endmodule

`default_nettype wire

>>> sv/circular_range_overlap_union.sv
// Top level: circular range overlap, union, ordering and point test.
// Depends on crou_pkg, crou_cmp and crou_resolve.
//
//   port group   dir   handshake               payload
//   input        in    in_valid / in_ready     a_*, b_*, point
//   result       out   out_valid / out_ready   ov_*, un_*, a_less .. point_inside
//   sort key     in    cfg_wr_en               cfg_wr_data
//
// One request per cycle sustained while out_ready stays high; a request passes
// through the input register, compare register and output register in turn.
// rst clears the stage valid bits and sets the sort key to wrapped size.
// Each stage holds while the one after it is full and stalled; in_ready
// stays high whenever some stage can advance.
`default_nettype none

module circular_range_overlap_union
  import crou_pkg::*;
(
  input  var logic       clk,
  input  var logic       rst,

  input  var logic       cfg_wr_en,
  input  var logic [1:0] cfg_wr_data,

  input  var logic       in_valid,
  output logic           in_ready,
  input  var angle_t     a_lower,
  input  var angle_t     a_upper,
  input  var logic       a_empty,
  input  var logic       a_full,
  input  var angle_t     b_lower,
  input  var angle_t     b_upper,
  input  var logic       b_empty,
  input  var logic       b_full,
  input  var angle_t     point,

  output logic           out_valid,
  input  var logic       out_ready,
  output angle_t         ov_lower,
  output angle_t         ov_upper,
  output logic           ov_empty,
  output logic           ov_full,
  output angle_t         un_lower,
  output angle_t         un_upper,
  output logic           un_empty,
  output logic           un_full,
  output logic           a_less,
  output logic           a_greater,
  output logic           a_equal,
  output logic           point_inside
);

  logic [1:0]   sort_key;

  // stage 1: captured request
  logic         v1;
  range_t       s1_a, s1_b;
  angle_t       s1_point;

  // stage 2: compare results
  logic         v2;
  crou_flags_t  s2_flags;
  angle_t       s2_a_lo, s2_a_up, s2_b_lo, s2_b_up;
  angle_t       s2_a_size, s2_b_size;

  // stage 3: output register
  logic         v3;
  crou_result_t s3_res;

  crou_flags_t  cmp_flags;
  angle_t       cmp_a_size, cmp_b_size;
  crou_result_t res_next;

  logic         adv1, adv2, adv3;

  assign adv3     = !v3 || out_ready;
  assign adv2     = !v2 || adv3;
  assign adv1     = !v1 || adv2;
  assign in_ready = adv1;

  always_ff @(posedge clk) begin
    if (rst) begin
      sort_key <= SORT_KEY_RESET;
    end else if (cfg_wr_en) begin
      sort_key <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (adv1) v1 <= in_valid;
      if (adv2) v2 <= v1;
      if (adv3) v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1 && in_valid) begin
      s1_a     <= '{lo: a_lower, up: a_upper, empty: a_empty, full: a_full};
      s1_b     <= '{lo: b_lower, up: b_upper, empty: b_empty, full: b_full};
      s1_point <= point;
    end
    if (adv2 && v1) begin
      s2_flags  <= cmp_flags;
      s2_a_lo   <= s1_a.lo;
      s2_a_up   <= s1_a.up;
      s2_b_lo   <= s1_b.lo;
      s2_b_up   <= s1_b.up;
      s2_a_size <= cmp_a_size;
      s2_b_size <= cmp_b_size;
    end
    if (adv3 && v2) begin
      s3_res <= res_next;
    end
  end

  crou_cmp u_cmp (
    .a      (s1_a),
    .b      (s1_b),
    .point  (s1_point),
    .flags  (cmp_flags),
    .a_size (cmp_a_size),
    .b_size (cmp_b_size)
  );

  crou_resolve u_resolve (
    .flags    (s2_flags),
    .a_lo     (s2_a_lo),
    .a_up     (s2_a_up),
    .b_lo     (s2_b_lo),
    .b_up     (s2_b_up),
    .a_size   (s2_a_size),
    .b_size   (s2_b_size),
    .sort_key (sort_key),
    .res      (res_next)
  );

  assign out_valid    = v3;
  assign ov_lower     = s3_res.ov.lo;
  assign ov_upper     = s3_res.ov.up;
  assign ov_empty     = s3_res.ov.empty;
  assign ov_full      = s3_res.ov.full;
  assign un_lower     = s3_res.un.lo;
  assign un_upper     = s3_res.un.up;
  assign un_empty     = s3_res.un.empty;
  assign un_full      = s3_res.un.full;
  assign a_less       = s3_res.a_less;
  assign a_greater    = s3_res.a_greater;
  assign a_equal      = s3_res.a_equal;
  assign point_inside = s3_res.point_inside;

  // a full overlap needs both operands full, so the union is full too
  assert property (@(posedge clk) disable iff (rst)
    out_valid && ov_full |-> un_full && !un_empty)
    else $error("full overlap without full union");

  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(a_less && a_greater))
    else $error("ordering reports both less and greater");

  // a stalled middle stage keeps its request
  assert property (@(posedge clk) disable iff (rst)
    v2 && !adv3 |=> v2 && $stable(s2_flags))
    else $error("compare stage dropped a stalled request");

endmodule

`default_nettype wire
